### hdl/sird_pkg.sv
package sird_pkg;

  localparam int NUM_W  = 32;
  localparam int CHAR_W = 8;
  localparam int DC_W   = 5;
  localparam int CFG_W  = 64;
  localparam int IDX_W_CFG = 2;

  localparam int MAX_DIGITS_DEFAULT = 16;

  localparam int BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES     = NUM_W / BITS_PER_CYCLE;
  localparam int STEP_W         = $clog2(DIV_CYCLES);

  localparam int NDIG   = NUM_W;
  localparam int NDIG_W = $clog2(NDIG);

  localparam logic [DC_W-1:0] DIGIT_COUNT_RESET = DC_W'(10);
  localparam logic [127:0]    ALPHABET_RESET    =
    {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [IDX_W_CFG-1:0] {
    REG_DIGIT_COUNT   = 2'd0,
    REG_ALPHABET_LOW  = 2'd1,
    REG_ALPHABET_HIGH = 2'd2
  } cfg_reg_e;

endpackage

### hdl/signed_int_to_radix_digits.sv
// Steps: accept in ST_IDLE, check the alphabet over digit_count entries, divide out each digit
// (4 quotient bits per cycle), then one character per cycle into the output register while
// the output is free. A new number is accepted only after its last character; an invalid
// alphabet or digit count yields a single invalid item instead.
// Reset (rst_ni low, asynchronous) clears control state and restores the radix 10
// alphabet "0123456789".
module signed_int_to_radix_digits #(
  parameter int MAX_DIGITS = sird_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sird_pkg::IDX_W_CFG-1:0] cfg_index_i,
  input  logic [sird_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [sird_pkg::NUM_W-1:0] number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sird_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_o,
  output logic                          invalid_o
);
  import sird_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_DIVIDE, ST_SIGN, ST_EMIT, ST_INVALID
  } state_e;

  state_e               state_q;
  logic [DC_W-1:0]      digit_count_q;
  logic [CHAR_W-1:0]    alph_q [MAX_DIGITS];
  logic                 neg_q;
  logic [NUM_W-1:0]     mag_q;
  logic [IDX_W-1:0]     rem_q;
  logic [STEP_W-1:0]    step_q;
  logic [IDX_W-1:0]     chk_q;
  logic [NDIG_W:0]      nd_q;
  logic [NDIG_W-1:0]    rd_q;
  logic [IDX_W-1:0]     dig_q [NDIG];
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;
  logic                 inv_q;

  logic [IDX_W:0]       radix;
  logic [NUM_W-1:0]     mag_d;
  logic [IDX_W-1:0]     rem_d;
  logic                 chk_hit;
  logic                 range_ok;
  logic                 out_free;
  logic                 emit_go;
  logic [NUM_W-1:0]     raw;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign invalid_o   = inv_q;

  assign radix    = digit_count_q[IDX_W:0];
  assign range_ok = (digit_count_q >= DC_W'(2)) && (digit_count_q <= DC_W'(MAX_DIGITS));
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_go  = out_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT) ||
                                 (state_q == ST_INVALID));
  assign raw      = number_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= DIGIT_COUNT_RESET;
      for (int j = 0; j < MAX_DIGITS; j++) begin
        alph_q[j] <= ALPHABET_RESET[j*CHAR_W +: CHAR_W];
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DIGIT_COUNT: digit_count_q <= cfg_data_i[DC_W-1:0];
        REG_ALPHABET_LOW: begin
          for (int j = 0; j < MAX_DIGITS; j++) begin
            if (j < 8) alph_q[j] <= cfg_data_i[(j%8)*CHAR_W +: CHAR_W];
          end
        end
        REG_ALPHABET_HIGH: begin
          for (int j = 0; j < MAX_DIGITS; j++) begin
            if (j >= 8) alph_q[j] <= cfg_data_i[(j%8)*CHAR_W +: CHAR_W];
          end
        end
        default: ;
      endcase
    end
  end

  // four restoring compare-subtract steps per cycle
  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    logic [NUM_W-1:0] m;
    r = rem_q;
    m = mag_q;
    t = '0;
    for (int s = 0; s < BITS_PER_CYCLE; s++) begin
      t = {r, m[NUM_W-1]};
      m = {m[NUM_W-2:0], (t >= radix)};
      if (t >= radix) t = t - radix;
      r = t[IDX_W-1:0];
    end
    mag_d = m;
    rem_d = r;
  end

  always_comb begin
    logic [CHAR_W-1:0] ca;
    ca = alph_q[chk_q];
    chk_hit = (ca == CHAR_PLUS) || (ca == CHAR_MINUS);
    for (int b = 0; b < MAX_DIGITS; b++) begin
      if ((b > int'(chk_q)) && (b < int'(digit_count_q)) && (alph_q[b] == ca)) begin
        chk_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      chk_q       <= '0;
      step_q      <= '0;
      nd_q        <= '0;
      rd_q        <= '0;
      rem_q       <= '0;
    end else begin
      if (emit_go) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            neg_q   <= raw[NUM_W-1];
            mag_q   <= raw[NUM_W-1] ? (~raw + NUM_W'(1)) : raw;
            chk_q   <= '0;
            state_q <= range_ok ? ST_CHECK : ST_INVALID;
          end
        end
        ST_CHECK: begin
          if (chk_hit) begin
            state_q <= ST_INVALID;
          end else if ({{(DC_W-IDX_W){1'b0}}, chk_q} == digit_count_q - DC_W'(1)) begin
            rem_q   <= '0;
            step_q  <= '0;
            nd_q    <= '0;
            state_q <= ST_DIVIDE;
          end else begin
            chk_q <= chk_q + IDX_W'(1);
          end
        end
        ST_DIVIDE: begin
          mag_q  <= mag_d;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_CYCLES - 1)) begin
            dig_q[nd_q[NDIG_W-1:0]] <= rem_d;
            nd_q  <= nd_q + (NDIG_W+1)'(1);
            rem_q <= '0;
            if ((mag_d == '0) || (nd_q == (NDIG_W+1)'(NDIG - 1))) begin
              rd_q    <= nd_q[NDIG_W-1:0];
              state_q <= neg_q ? ST_SIGN : ST_EMIT;
            end
          end else begin
            rem_q <= rem_d;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            char_q      <= CHAR_MINUS;
            last_q      <= 1'b0;
            inv_q       <= 1'b0;
            state_q     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            char_q      <= alph_q[dig_q[rd_q]];
            last_q      <= (rd_q == '0);
            inv_q       <= 1'b0;
            if (rd_q == '0) state_q <= ST_IDLE;
            else rd_q <= rd_q - NDIG_W'(1);
          end
        end
        ST_INVALID: begin
          if (out_free) begin
            char_q      <= '0;
            last_q      <= 1'b1;
            inv_q       <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_invalid_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> last_o && (character_o == '0))
    else $error("invalid item without last or with a character");

  a_nd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= (NDIG_W+1)'(NDIG))
    else $error("digit count beyond buffer");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> ({1'b0, rem_q} < radix))
    else $error("remainder not below radix");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready again straight after an accepted item");

endmodule
